// ----- rtl/bitmap_first_fit_block_allocator_assert.svh -----
// Assertion helpers for the checker file of this block.
// SAME checks the consequent in the same cycle, NEXT in the cycle after.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`define BFFA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

`define BFFA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bffa_pkg.sv -----
`default_nettype none

package bffa_pkg;

	// map geometry
	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_W     = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
	localparam int OFF_W      = $clog2(WORD_W);
	localparam int REL_W      = OFF_W + 1;
	localparam int WORD_CNT   = NUM_BLOCKS / WORD_W;
	localparam int ADDR_W     = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;

	// port field widths
	localparam int TYPE_W  = 2;
	localparam int COUNT_W = 13;
	localparam int START_W = 12;
	localparam int POS_W   = 13;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 1;

	// internal block counts: hold NUM_BLOCKS, any register value and start + count
	localparam int BLK_W = $clog2(NUM_BLOCKS + 1);
	localparam int CNT_W = ((BLK_W > CFG_W) ? BLK_W : CFG_W) + 1;

	localparam logic [TYPE_W-1:0] REQ_INIT  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd2;

	localparam logic [IDX_W-1:0] REG_TOTAL    = 1'b0;
	localparam logic [IDX_W-1:0] REG_RESERVED = 1'b1;

	localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;
	localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MODIFY,
		ST_FLUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             hit;
		logic [OFF_W-1:0] hit_off;
		logic [CNT_W-1:0] run_out;
	} scan_res_t;

	typedef struct packed {
		logic keep;
		logic set;
	} mod_op_t;

	// low n bits set, n in 0..WORD_W
	function automatic logic [WORD_W-1:0] ones_below(input logic [REL_W-1:0] n);
		logic [WORD_W:0] t;
		t = ({{WORD_W{1'b0}}, 1'b1} << n) - {{WORD_W{1'b0}}, 1'b1};
		return t[WORD_W-1:0];
	endfunction

	// x relative to a word base, clamped to 0..WORD_W
	function automatic logic [REL_W-1:0] rel_clamp(input logic [CNT_W-1:0] x,
		input logic [CNT_W-1:0] base);
		logic [CNT_W-1:0] d;
		d = x - base;
		if (x <= base) begin
			return '0;
		end else if (d >= CNT_W'(WORD_W)) begin
			return REL_W'(WORD_W);
		end else begin
			return d[REL_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bffa_map_ram.sv -----
`default_nettype none

module bffa_map_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bffa_word_scan.sv -----
`default_nettype none

// One map word of the first-fit search: a run either continues from the
// previous words into the low end of this word, or fits inside the word.
module bffa_word_scan import bffa_pkg::*; (
	input  wire logic [WORD_W-1:0] used,
	input  wire logic [REL_W-1:0]  lim_rel,
	input  wire logic [CNT_W-1:0]  run_in,
	input  wire logic [CNT_W-1:0]  count,
	output scan_res_t              res
);

	logic [WORD_W-1:0] free;
	logic [WORD_W-1:0] p [OFF_W+1];
	logic [WORD_W-1:0] acc;
	logic [REL_W-1:0]  tz;
	logic [REL_W-1:0]  lz;
	logic [OFF_W-1:0]  win_off;
	logic [CNT_W-1:0]  cross_off;
	logic              found_tz;
	logic              found_lz;
	logic              first;
	logic              win_hit;
	logic              cross_ok;

	always_comb begin
		// blocks past the scan limit count as used
		free = ~used & ones_below(lim_rel);

		tz = REL_W'(WORD_W);
		found_tz = 1'b0;
		for (int i = 0; i < WORD_W; i++) begin
			if (!found_tz && !free[i]) begin
				tz = REL_W'(i);
				found_tz = 1'b1;
			end
		end

		lz = REL_W'(WORD_W);
		found_lz = 1'b0;
		for (int i = 0; i < WORD_W; i++) begin
			if (!found_lz && !free[WORD_W-1-i]) begin
				lz = REL_W'(i);
				found_lz = 1'b1;
			end
		end

		// p[k][b]: 2**k free blocks end at b
		p[0] = free;
		for (int k = 1; k <= OFF_W; k++) begin
			p[k] = p[k-1] & (p[k-1] << (1 << (k - 1)));
		end

		// stitch windows by the bits of count
		acc = '0;
		first = 1'b1;
		for (int k = 0; k <= OFF_W; k++) begin
			if (count[k]) begin
				acc = first ? p[k] : (p[k] & (acc << (1 << k)));
				first = 1'b0;
			end
		end

		win_off = '0;
		win_hit = 1'b0;
		for (int i = 0; i < WORD_W; i++) begin
			if (!win_hit && acc[i]) begin
				win_off = OFF_W'(i);
				win_hit = 1'b1;
			end
		end
		win_hit = win_hit && (count <= CNT_W'(WORD_W));

		// a continued run always ends no later than one inside the word
		cross_ok  = count <= (run_in + CNT_W'(tz));
		cross_off = count - run_in - CNT_W'(1);

		res.hit     = cross_ok || win_hit;
		res.hit_off = cross_ok ? cross_off[OFF_W-1:0] : win_off;
		res.run_out = (tz == REL_W'(WORD_W)) ? (run_in + CNT_W'(WORD_W)) : CNT_W'(lz);
	end

endmodule

`default_nettype wire

// ----- rtl/bitmap_first_fit_block_allocator.sv -----
// First-fit bitmap allocator: one used bit per storage block, held in a
// word-wide map RAM (32 bits per word, 128 words for 4096 blocks).
// Request channel (req_valid / req_stall): req_type 0 init, 1 allocate,
// 2 free, 3 no-op. Response channel (rsp_valid / rsp_stall): one response
// per request, status 1 means out of space, position the run start (alloc)
// or start_block + reserved_blocks (init), zero otherwise.
// Config: cfg_wen writes total_blocks (index 0) or reserved_blocks (index 1);
// only write while no request is in flight.
// Latency, accept edge to rsp_valid: init sweeps every word, WORD_CNT + 2
// (130). Free sweeps the words it touches (at least one), words + 2.
// Allocate scans one word a cycle until the run ends, then marks the run's
// words: scanned + marked + 3; a miss answers after the whole scan, scanned
// + 2. Zero count, zero total and type 3 answer after 1. The RAM's single
// read and write port, one word a cycle, sets every figure. One request is
// in flight at a time; the next is taken the cycle after the response loads.
// Reset: the map is cleared by a pass over all WORD_CNT words (129 cycles)
// during which req_stall is high; config writes are taken as ever.
// A stalled response sits in the output register; the next request may be
// accepted meanwhile and its own result waits until the register frees.
`default_nettype none

module bitmap_first_fit_block_allocator import bffa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [TYPE_W-1:0]  req_type,
	input  wire logic [COUNT_W-1:0] run_len,
	input  wire logic [START_W-1:0] start_block,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic                    status,
	output logic      [POS_W-1:0]   position,
	input  wire logic               cfg_wen,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata
);

	state_t state_q, state_d;

	// config registers
	logic [CFG_W-1:0] total_q;
	logic [CFG_W-1:0] reserved_q;

	// sweep control
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] last_q;
	logic              more_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	mod_op_t           op_q;
	logic              quiet_q;

	// request payload and running scan state
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] run_q;
	logic             res_status_q;
	logic [POS_W-1:0] res_pos_q;

	// read-data stage
	logic              scan_v_s1;
	logic              mod_v_s1;
	logic [ADDR_W-1:0] addr_s1;

	// response register
	logic             rsp_valid_q;
	logic             status_q;
	logic [POS_W-1:0] position_q;

	// RAM
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] mask;

	// combinational helpers
	logic             accept;
	logic             issue_scan;
	logic             issue_mod;
	logic             can_load;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] lim_m1;
	logic [CNT_W-1:0] init_hi;
	logic [CNT_W-1:0] start_ext;
	logic [CNT_W-1:0] free_end;
	logic [CNT_W-1:0] free_hi;
	logic [CNT_W-1:0] free_hi_m1;
	logic             free_any;
	logic [CNT_W-1:0] init_pos;
	logic [CNT_W-1:0] base_s1;
	logic [CNT_W-1:0] hit_end;
	logic [CNT_W-1:0] hit_first;
	logic             hit_now;
	logic             scan_end;
	logic             alloc_nil;
	scan_res_t        sres;

	bffa_map_ram #(
		.DATA_W (WORD_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (mod_v_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	bffa_word_scan u_scan (
		.used    (rd_data),
		.lim_rel (rel_clamp(lim, base_s1)),
		.run_in  (run_q),
		.count   (count_q),
		.res     (sres)
	);

	// scan limit and per-request bounds
	always_comb begin
		lim        = (CNT_W'(total_q) > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
			: CNT_W'(total_q);
		lim_m1     = lim - CNT_W'(1);
		init_hi    = (CNT_W'(reserved_q) > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
			: CNT_W'(reserved_q);
		start_ext  = CNT_W'(start_block);
		free_end   = start_ext + CNT_W'(run_len);
		free_hi    = (free_end > lim) ? lim : free_end;
		free_hi_m1 = free_hi - CNT_W'(1);
		free_any   = free_hi > start_ext;
		init_pos   = start_ext + CNT_W'(reserved_q);
		alloc_nil  = (run_len == '0) || (lim == '0);
	end

	// read stage: word base, hit position, modify mask
	always_comb begin
		base_s1   = CNT_W'({addr_s1, {OFF_W{1'b0}}});
		hit_end   = base_s1 + CNT_W'(sres.hit_off);
		hit_first = hit_end + CNT_W'(1) - count_q;
		hit_now   = scan_v_s1 && sres.hit;
		scan_end  = scan_v_s1 && !sres.hit && (addr_s1 == last_q);
		mask      = ones_below(rel_clamp(hi_q, base_s1)) & ~ones_below(rel_clamp(lo_q, base_s1));
		wr_data   = (op_q.keep ? (rd_data & ~mask) : '0) | (op_q.set ? mask : '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_INIT:  state_d = ST_MODIFY;
						REQ_ALLOC: state_d = alloc_nil ? ST_DONE : ST_SCAN;
						REQ_FREE:  state_d = ST_MODIFY;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit_now) begin
					state_d = ST_MODIFY;
				end else if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_MODIFY: begin
				if (addr_q == last_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = quiet_q ? ST_IDLE : ST_DONE;
			end
			ST_DONE: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		req_stall  = state_q != ST_IDLE;
		accept     = req_valid && (state_q == ST_IDLE);
		issue_scan = (state_q == ST_SCAN) && more_q;
		issue_mod  = state_q == ST_MODIFY;
		rd_en      = issue_scan || issue_mod;
		can_load   = !rsp_valid_q || !rsp_stall;
		rsp_valid  = rsp_valid_q;
		status     = status_q;
		position   = position_q;
	end

	// control registers; reset starts the clearing pass (empty mask, no keep)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MODIFY;
			total_q     <= TOTAL_RST;
			reserved_q  <= RESERVED_RST;
			addr_q      <= '0;
			last_q      <= ADDR_W'(WORD_CNT - 1);
			more_q      <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			op_q        <= '{keep: 1'b0, set: 1'b1};
			quiet_q     <= 1'b1;
			scan_v_s1   <= 1'b0;
			mod_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= issue_scan && !hit_now;
			mod_v_s1  <= issue_mod;

			if (cfg_wen) begin
				case (cfg_index)
					REG_TOTAL:    total_q    <= cfg_wdata;
					REG_RESERVED: reserved_q <= cfg_wdata;
					default:      ;
				endcase
			end

			if (accept) begin
				case (req_type)
					REQ_INIT: begin
						addr_q <= '0;
						last_q <= ADDR_W'(WORD_CNT - 1);
						lo_q   <= '0;
						hi_q   <= init_hi;
						op_q   <= '{keep: 1'b0, set: 1'b1};
					end
					REQ_ALLOC: begin
						addr_q <= '0;
						last_q <= lim_m1[OFF_W +: ADDR_W];
						more_q <= 1'b1;
					end
					REQ_FREE: begin
						addr_q <= free_any ? start_ext[OFF_W +: ADDR_W] : '0;
						last_q <= free_any ? free_hi_m1[OFF_W +: ADDR_W] : '0;
						lo_q   <= start_ext;
						hi_q   <= free_hi;
						op_q   <= '{keep: 1'b1, set: 1'b0};
					end
					default: ;
				endcase
			end else if (hit_now) begin
				// mark pass over the found run
				addr_q <= hit_first[OFF_W +: ADDR_W];
				last_q <= hit_end[OFF_W +: ADDR_W];
				lo_q   <= hit_first;
				hi_q   <= hit_end + CNT_W'(1);
				op_q   <= '{keep: 1'b1, set: 1'b1};
				more_q <= 1'b0;
			end else if (issue_scan) begin
				addr_q <= addr_q + ADDR_W'(1);
				if (addr_q == last_q) begin
					more_q <= 1'b0;
				end
			end else if (issue_mod) begin
				addr_q <= addr_q + ADDR_W'(1);
			end

			if (state_q == ST_FLUSH) begin
				quiet_q <= 1'b0;
			end

			if ((state_q == ST_DONE) && can_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;

		if (accept) begin
			count_q <= CNT_W'(run_len);
			run_q   <= '0;
			case (req_type)
				REQ_INIT: begin
					res_status_q <= 1'b0;
					res_pos_q    <= init_pos[POS_W-1:0];
				end
				REQ_ALLOC: begin
					// miss by default; a hit overwrites
					res_status_q <= 1'b1;
					res_pos_q    <= '0;
				end
				default: begin
					res_status_q <= 1'b0;
					res_pos_q    <= '0;
				end
			endcase
		end else if (hit_now) begin
			res_status_q <= 1'b0;
			res_pos_q    <= hit_first[POS_W-1:0];
		end else if (scan_v_s1) begin
			run_q <= sres.run_out;
		end

		if ((state_q == ST_DONE) && can_load) begin
			status_q   <= res_status_q;
			position_q <= res_pos_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bffa_checker.sv -----
`default_nettype none

`include "bitmap_first_fit_block_allocator_assert.svh"

module bffa_checker import bffa_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire logic             status,
	input wire logic [POS_W-1:0] position
);

	`BFFA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
	`BFFA_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(status) && $stable(position), "stalled response changed")
	`BFFA_ASSERT_SAME(a_oos_pos, clk, arst_n, rsp_valid && status, position == '0, "out-of-space response with nonzero position")
	`BFFA_ASSERT_NEXT(a_one_req, clk, arst_n, req_valid && !req_stall, req_stall, "second request taken while one is in flight")
	`BFFA_ASSERT_NEXT(a_no_early_rsp, clk, arst_n, req_valid && !req_stall && !rsp_valid, !rsp_valid, "response right after request")

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.position  (position)
);

`default_nettype wire
